// ===== src/pab_pkg.sv =====
// shared types and constants for the premultiplied alpha blend pipeline
package pab_pkg;

  localparam int CH_W       = 8;             // bits per color channel
  localparam int NUM_CH     = 3;             // red, green, blue
  localparam int DIVIDEND_W = 2 * CH_W;      // 255 * c needs 16 bits
  localparam int DIV_STEPS  = DIVIDEND_W;    // one quotient bit per cell
  localparam int SUM_W      = 2 * CH_W;      // f*a + b*(255-a) <= 65025

  localparam logic [CH_W-1:0] OPAQUE_ALPHA      = 8'hff;
  localparam logic [CH_W-1:0] TRANSPARENT_ALPHA = 8'h00;
  localparam logic [CH_W-1:0] FULL_SCALE        = 8'd255;

  // payload carried from cell to cell along the divider chain
  typedef struct packed {
    logic [CH_W-1:0]                   alpha;
    logic                              last;
    logic [NUM_CH-1:0][CH_W-1:0]       fore;
    logic [NUM_CH-1:0][CH_W-1:0]       back;
    logic [NUM_CH-1:0][DIVIDEND_W-1:0] dividend;
    logic [NUM_CH-1:0][CH_W-1:0]       rem;
    logic [NUM_CH-1:0][CH_W-1:0]       quot;
  } stage_t;

  // finished pixel
  typedef struct packed {
    logic [NUM_CH-1:0][CH_W-1:0] rgb;
    logic                        last;
  } pixel_t;

endpackage

// ===== src/pab_div_cell.sv =====
// one restoring division step for all three channels, registered
module pab_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  pab_pkg::stage_t in_stage,
  output logic            out_valid,
  output pab_pkg::stage_t out_stage
);

  pab_pkg::stage_t                          stage_next;
  logic [pab_pkg::NUM_CH-1:0][pab_pkg::CH_W:0] shifted;
  logic [pab_pkg::NUM_CH-1:0][pab_pkg::CH_W:0] diff;
  logic [pab_pkg::NUM_CH-1:0]                  qbit;

  always_comb begin
    stage_next = in_stage;
    for (int ch = 0; ch < pab_pkg::NUM_CH; ch++) begin
      // bring down the next dividend bit
      shifted[ch] = {in_stage.rem[ch], in_stage.dividend[ch][pab_pkg::DIVIDEND_W-1]};
      diff[ch]    = shifted[ch] - {1'b0, in_stage.alpha};
      qbit[ch]    = (shifted[ch] >= {1'b0, in_stage.alpha});
      stage_next.rem[ch]      = qbit[ch] ? diff[ch][pab_pkg::CH_W-1:0]
                                         : shifted[ch][pab_pkg::CH_W-1:0];
      stage_next.dividend[ch] = {in_stage.dividend[ch][pab_pkg::DIVIDEND_W-2:0], 1'b0};
      // only the low byte of the quotient is kept
      stage_next.quot[ch]     = {in_stage.quot[ch][pab_pkg::CH_W-2:0], qbit[ch]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

// ===== src/pab_mix.sv =====
// blend of un-premultiplied overlay with video, two register stages
module pab_mix (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  pab_pkg::stage_t in_stage,
  output logic            out_valid,
  output pab_pkg::pixel_t out_pixel
);

  typedef enum logic [1:0] {
    MODE_BACK,
    MODE_FORE,
    MODE_MIX
  } mode_t;

  mode_t                                           mode_sel;
  mode_t                                           mode_a;
  logic                                            valid_a;
  logic                                            last_a;
  logic [pab_pkg::NUM_CH-1:0][pab_pkg::CH_W-1:0]   fore_a;
  logic [pab_pkg::NUM_CH-1:0][pab_pkg::CH_W-1:0]   back_a;
  logic [pab_pkg::NUM_CH-1:0][pab_pkg::SUM_W-1:0]  sum_next;
  logic [pab_pkg::NUM_CH-1:0][pab_pkg::SUM_W-1:0]  sum_a;
  logic [pab_pkg::NUM_CH-1:0][pab_pkg::SUM_W:0]    scaled;
  pab_pkg::pixel_t                                 pixel_next;
  logic [pab_pkg::CH_W-1:0]                        inv_alpha;

  assign inv_alpha = pab_pkg::FULL_SCALE - in_stage.alpha;

  always_comb begin
    if (in_stage.alpha == pab_pkg::TRANSPARENT_ALPHA) begin
      mode_sel = MODE_BACK;
    end else if (in_stage.alpha == pab_pkg::OPAQUE_ALPHA) begin
      mode_sel = MODE_FORE;
    end else begin
      mode_sel = MODE_MIX;
    end
    for (int ch = 0; ch < pab_pkg::NUM_CH; ch++) begin
      sum_next[ch] = in_stage.quot[ch] * in_stage.alpha
                   + in_stage.back[ch] * inv_alpha;
    end
  end

  // stage a: products and sum
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (en) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_a <= mode_sel;
      last_a <= in_stage.last;
      fore_a <= in_stage.fore;
      back_a <= in_stage.back;
      sum_a  <= sum_next;
    end
  end

  // stage b: divide by 255, exact for every sum up to 65025, then select
  always_comb begin
    pixel_next.last = last_a;
    for (int ch = 0; ch < pab_pkg::NUM_CH; ch++) begin
      scaled[ch] = {1'b0, sum_a[ch]} + (pab_pkg::SUM_W+1)'(1)
                 + {(pab_pkg::CH_W+1)'(0), sum_a[ch][pab_pkg::SUM_W-1:pab_pkg::CH_W]};
      case (mode_a)
        MODE_BACK: pixel_next.rgb[ch] = back_a[ch];
        MODE_FORE: pixel_next.rgb[ch] = fore_a[ch];
        MODE_MIX:  pixel_next.rgb[ch] = scaled[ch][pab_pkg::SUM_W-1:pab_pkg::CH_W];
        default:   pixel_next.rgb[ch] = back_a[ch];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pixel <= pixel_next;
    end
  end

endmodule

// ===== src/premultiplied_alpha_blend.sv =====
// top level: premultiplied argb overlay composited over an rgb video stream
//
// usage
//   slave channel s_*: one request per pixel, overlay argb plus video rgb,
//   s_tlast marks the last pixel of a frame. master channel m_*: one blended
//   rgb pixel per request, in order, m_tlast copies s_tlast.
// throughput
//   one pixel per clock sustained while m_tready is high. the overlay channel
//   is un-premultiplied by a chain of 16 division cells, one quotient bit per
//   cell, followed by a two-stage blend (multiply/add, then divide by 255).
// datapath
//   an accepted request passes through 16 cells, 2 blend stages and the
//   output register on its way to m_tvalid.
// stall behavior
//   a skid register sits behind the output register. when m_tready drops the
//   pixel in flight lands in the skid and the whole chain freezes; s_tready
//   is low only while the skid is full, so s_tready never depends on
//   m_tready within the same cycle.
// reset
//   rst (synchronous, active high) clears every valid bit; no pixel is held
//   and s_tready is high in the first cycle after reset.
module premultiplied_alpha_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // front_red, front_green, front_blue, front_alpha, back_red, back_green, back_blue
  input  logic [55:0] s_tdata,
  input  logic        s_tlast,    // last_pixel
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_red, out_green, out_blue
  output logic [23:0] m_tdata,
  output logic        m_tlast     // out_last
);

  localparam int CH_W   = pab_pkg::CH_W;
  localparam int NUM_CH = pab_pkg::NUM_CH;
  localparam int STEPS  = pab_pkg::DIV_STEPS;

  // chain element 0 is the incoming request, element k the output of cell k-1
  logic            chain_valid [0:STEPS];
  pab_pkg::stage_t chain_stage [0:STEPS];

  logic            en;
  logic            mix_valid;
  pab_pkg::pixel_t mix_pixel;
  logic            skid_valid;
  pab_pkg::pixel_t skid_pixel;
  logic            out_free;

  // chain advances whenever the skid can absorb what leaves it
  assign en       = !skid_valid;
  assign s_tready = en;
  assign out_free = !m_tvalid || m_tready;

  // unpack the request and form the dividend 255 * c
  always_comb begin
    chain_valid[0]       = s_tvalid;
    chain_stage[0].alpha = s_tdata[3*CH_W +: CH_W];
    chain_stage[0].last  = s_tlast;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      chain_stage[0].fore[ch]     = s_tdata[ch*CH_W +: CH_W];
      chain_stage[0].back[ch]     = s_tdata[(ch+4)*CH_W +: CH_W];
      chain_stage[0].dividend[ch] = {s_tdata[ch*CH_W +: CH_W], {CH_W{1'b0}}}
                                  - {{CH_W{1'b0}}, s_tdata[ch*CH_W +: CH_W]};
      chain_stage[0].rem[ch]      = '0;
      chain_stage[0].quot[ch]     = '0;
    end
  end

  // division chain, one quotient bit per cell
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    pab_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[k]),
      .in_stage  (chain_stage[k]),
      .out_valid (chain_valid[k+1]),
      .out_stage (chain_stage[k+1])
    );
  end

  pab_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (chain_valid[STEPS]),
    .in_stage  (chain_stage[STEPS]),
    .out_valid (mix_valid),
    .out_pixel (mix_pixel)
  );

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_free) begin
      m_tvalid <= mix_valid;
    end else if (mix_valid) begin
      // receiver stalled, park the pixel leaving the blend
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        m_tdata <= skid_pixel.rgb;
        m_tlast <= skid_pixel.last;
      end
    end else if (out_free) begin
      m_tdata <= mix_pixel.rgb;
      m_tlast <= mix_pixel.last;
    end else begin
      skid_pixel <= mix_pixel;
    end
  end

  // the skid holds a pixel only behind a pending output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds a pixel with no output pending");

  // the skid fills only when the receiver stalls a valid output
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid filled without a stalled output");

  // a pixel leaving the last cell while the chain moves enters the blend
  a_chain_to_mix: assert property (@(posedge clk) disable iff (rst)
    (en && chain_valid[STEPS]) |=> u_mix.valid_a)
    else $error("pixel lost between division chain and blend");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the premultiplied alpha blend pipeline
`timescale 1ns / 100ps

module tb;

  // request layout mirrors {s_tlast, s_tdata}, front_red in the lowest bits
  typedef struct packed {
    logic                     last;
    logic [pab_pkg::CH_W-1:0] back_blue;
    logic [pab_pkg::CH_W-1:0] back_green;
    logic [pab_pkg::CH_W-1:0] back_red;
    logic [pab_pkg::CH_W-1:0] front_alpha;
    logic [pab_pkg::CH_W-1:0] front_blue;
    logic [pab_pkg::CH_W-1:0] front_green;
    logic [pab_pkg::CH_W-1:0] front_red;
  } pixel_req_t;

  // holds the blended pixels still owed by the block, oldest first
  class pixel_scoreboard;
    pab_pkg::pixel_t expected_pixels[$];
    int unsigned     mismatches;
    int unsigned     checked;

    // composite one overlay pixel over one video pixel
    function pab_pkg::pixel_t blend_pixel(pixel_req_t px);
      pab_pkg::pixel_t                               res;
      logic [pab_pkg::NUM_CH-1:0][pab_pkg::CH_W-1:0] fore;
      logic [pab_pkg::NUM_CH-1:0][pab_pkg::CH_W-1:0] back;
      logic [pab_pkg::DIVIDEND_W-1:0]                straight;
      logic [pab_pkg::SUM_W-1:0]                     mix;
      int                                            ch;
      fore = {px.front_blue, px.front_green, px.front_red};
      back = {px.back_blue, px.back_green, px.back_red};
      res.last = px.last;
      for (ch = 0; ch < pab_pkg::NUM_CH; ch++) begin
        if (px.front_alpha == pab_pkg::TRANSPARENT_ALPHA) begin
          res.rgb[ch] = back[ch];
        end else if (px.front_alpha == pab_pkg::OPAQUE_ALPHA) begin
          res.rgb[ch] = fore[ch];
        end else begin
          // un-premultiply, only the low byte survives when c > alpha
          straight = (pab_pkg::FULL_SCALE * fore[ch]) / px.front_alpha;
          mix = ({8'd0, straight[pab_pkg::CH_W-1:0]} * px.front_alpha
                 + back[ch] * (pab_pkg::FULL_SCALE - px.front_alpha)) / pab_pkg::FULL_SCALE;
          res.rgb[ch] = mix[pab_pkg::CH_W-1:0];
        end
      end
      return res;
    endfunction

    function void note_request(pixel_req_t px);
      expected_pixels.push_back(blend_pixel(px));
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      if (mismatches < 100)
        $display("mismatch at pixel %0d: %s got 0x%0h expected 0x%0h",
                 checked, what, got, want);
      mismatches++;
    endtask

    task check_pixel(pab_pkg::pixel_t got);
      pab_pkg::pixel_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch("pixel with nothing pending", got, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (got.rgb[0] !== want.rgb[0]) report_mismatch("red", got.rgb[0], want.rgb[0]);
        if (got.rgb[1] !== want.rgb[1]) report_mismatch("green", got.rgb[1], want.rgb[1]);
        if (got.rgb[2] !== want.rgb[2]) report_mismatch("blue", got.rgb[2], want.rgb[2]);
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      end
      checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // front r, g, b, alpha, back r, g, b
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // out r, g, b
  logic        m_tlast;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  pixel_scoreboard blend_sb = new();

  premultiplied_alpha_blend u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // sink side backpressure, redrawn every cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // both handshakes sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) blend_sb.note_request({s_tlast, s_tdata});
      if (m_tvalid && m_tready) blend_sb.check_pixel({m_tdata, m_tlast});
    end
  end

  function automatic pixel_req_t make_pixel(
    logic [7:0] fr, logic [7:0] fg, logic [7:0] fb, logic [7:0] fa,
    logic [7:0] br, logic [7:0] bg, logic [7:0] bb, logic lst);
    pixel_req_t px;
    px = {lst, bb, bg, br, fa, fb, fg, fr};
    return px;
  endfunction

  // mostly well-formed premultiplied channels, some above alpha
  function automatic logic [7:0] random_channel(logic [7:0] alpha);
    if ($urandom_range(99) < 80) return 8'($urandom_range(alpha));
    return 8'($urandom_range(255));
  endfunction

  function automatic pixel_req_t random_pixel();
    pixel_req_t  px;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8)       px.front_alpha = pab_pkg::TRANSPARENT_ALPHA;
    else if (pick < 16) px.front_alpha = pab_pkg::OPAQUE_ALPHA;
    else if (pick < 22) px.front_alpha = ($urandom_range(1) != 0) ? 8'd1 : 8'd254;
    else                px.front_alpha = 8'($urandom_range(254, 1));
    px.front_red   = random_channel(px.front_alpha);
    px.front_green = random_channel(px.front_alpha);
    px.front_blue  = random_channel(px.front_alpha);
    px.back_red    = 8'($urandom_range(255));
    px.back_green  = 8'($urandom_range(255));
    px.back_blue   = 8'($urandom_range(255));
    px.last        = ($urandom_range(15) == 0);
    return px;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_pixel(input pixel_req_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px[55:0];
    s_tlast  <= px.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_directed();
    // transparent overlay: video passes
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'h00, 8'h12, 8'h34, 8'h56, 1'b0));
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 1'b1));
    // opaque overlay: overlay passes as given
    send_pixel(make_pixel(8'hff, 8'h00, 8'h80, 8'hff, 8'h11, 8'h22, 8'h33, 1'b0));
    send_pixel(make_pixel(8'h00, 8'hff, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0));
    // small alpha (1 to 3), channels below, at and far above alpha; those above wrap
    send_pixel(make_pixel(8'h00, 8'h01, 8'hff, 8'h01, 8'h00, 8'hff, 8'h80, 1'b0));
    send_pixel(make_pixel(8'h01, 8'h01, 8'h01, 8'h01, 8'hff, 8'hff, 8'hff, 1'b0));
    send_pixel(make_pixel(8'h02, 8'h03, 8'hff, 8'h02, 8'haa, 8'h55, 8'hff, 1'b0));
    send_pixel(make_pixel(8'h01, 8'h02, 8'h03, 8'h03, 8'hfe, 8'hfd, 8'hfc, 1'b0));
    // largest partial alpha
    send_pixel(make_pixel(8'hfe, 8'hfe, 8'h00, 8'hfe, 8'h00, 8'hff, 8'hff, 1'b0));
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hfe, 8'h00, 8'h00, 8'h00, 1'b0));
    // mid alpha, in range and above range
    send_pixel(make_pixel(8'h80, 8'h40, 8'h00, 8'h80, 8'hff, 8'h00, 8'h7f, 1'b0));
    send_pixel(make_pixel(8'hc8, 8'hff, 8'h81, 8'h80, 8'h55, 8'haa, 8'h00, 1'b0));
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'h80, 8'hff, 8'hff, 8'hff, 1'b0));
    send_pixel(make_pixel(8'h7f, 8'h00, 8'h3f, 8'h7f, 8'h01, 8'h02, 8'h03, 1'b1));
    send_pixel(make_pixel(8'haa, 8'h55, 8'h2a, 8'h55, 8'h80, 8'h80, 8'h80, 1'b0));
    send_pixel(make_pixel(8'h55, 8'haa, 8'hff, 8'haa, 8'h55, 8'haa, 8'hff, 1'b1));
  endtask

  // phases: free flow, sparse source, heavy backpressure, both moderate
  task automatic send_random_phase(int unsigned idle, int unsigned stall, int count);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) send_pixel(random_pixel());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_directed();
    send_random_phase(0, 0, 240);
    send_random_phase(84, 0, 240);
    send_random_phase(0, 84, 240);
    send_random_phase(30, 30, 240);
    s_tvalid <= 1'b0;
    stall_pct = 0;
    while (blend_sb.pending() != 0) @(posedge clk);
    // let any stray pixel surface past the pipeline depth
    repeat (40) @(posedge clk);
    if (blend_sb.mismatches == 0) begin
      $display("premultiplied_alpha_blend test passed");
    end else begin
      $display("premultiplied_alpha_blend test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("premultiplied_alpha_blend test failed");
    $finish;
  end

endmodule

// ===== premultiplied_alpha_blend.f =====
src/pab_pkg.sv
src/pab_div_cell.sv
src/pab_mix.sv
src/premultiplied_alpha_blend.sv
tb/tb.sv
